>>> hw/rtl/particle_pool_update_engine_core_macros.svh
// Assertion macros used by the checker of the particle pool engine.
`ifndef PARTICLE_POOL_UPDATE_ENGINE_CORE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ppu_pkg.sv
package ppu_pkg;

  // Item kinds.
  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DRAG    = 1'b0;
  localparam logic CFG_GRAVITY = 1'b1;

  localparam logic [15:0] DRAG_RESET = 16'hFFFF;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [15:0]        size;
    logic [23:0]        color;
    logic [15:0]        lifetime;
    logic [15:0]        dt;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               present;
    logic signed [23:0] draw_x;
    logic signed [23:0] draw_y;
    logic [15:0]        draw_size;
    logic [23:0]        draw_color;
    logic [7:0]         alpha;
    logic               last;
  } res_item_t;

  // One stored particle.
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [15:0]        life;
    logic [15:0]        life_max;
    logic [15:0]        size;
    logic [23:0]        color;
  } part_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic spawn;
    logic rd_slot;
    logic mul1;
    logic vel;
    logic mul2;
    logic upd;
    logic div_step;
    logic emit_tick;
    logic emit_end;
  } ppu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pool_empty;
    logic alive_cur;
    logic die;
  } ppu_stat_t;

  // Saturate a wide signed value to the signed 24-bit range.
  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/particle_pool_update_engine_core.sv
// Channel   Signals                          Transfer
// --------  -------------------------------  ---------------------------------
// item      start, busy, item                start high while busy is low
// config    cfg_we, cfg_index, cfg_data      cfg_we high, no wait
// result    result_valid, result             result_valid high, no stall
//
// A spawn passes through the spawn state to its single registered result.
// A tick walks all POOL_SLOTS slots in ascending order, one particle at a
// time through the shared multipliers and divider: a live slot passes the
// multiply, velocity, second multiply and update states, and a surviving
// slot then the divider and emit states, before the closing result.
// Synchronous reset clears the free stack to all slots and no live particles.
// The receiver cannot stall: each result is shown for exactly one cycle.
module particle_pool_update_engine_core #(
  parameter int POOL_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ppu_pkg::in_item_t  item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               result_valid,
  output ppu_pkg::res_item_t result
);
  import ppu_pkg::*;

  ppu_cmd_t                      cmd;
  ppu_stat_t                     stat;
  logic [$clog2(POOL_SLOTS)-1:0] idx;

  // Sequencer.
  ppu_ctrl #(.POOL_SLOTS(POOL_SLOTS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .kind (item.kind),
    .stat (stat),
    .cmd  (cmd),
    .idx  (idx),
    .busy (busy)
  );

  // Storage and arithmetic.
  ppu_dp #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .idx         (idx),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

>>> hw/rtl/ppu_ctrl.sv
module ppu_ctrl #(
  parameter int POOL_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          kind,
  input  ppu_pkg::ppu_stat_t            stat,
  output ppu_pkg::ppu_cmd_t             cmd,
  output logic [$clog2(POOL_SLOTS)-1:0] idx,
  output logic                          busy
);
  import ppu_pkg::*;

  localparam int AW = $clog2(POOL_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(POOL_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SPAWN, S_SCAN, S_MUL1, S_VEL, S_MUL2, S_UPD, S_DIV, S_EMIT, S_END
  } state_t;

  state_t     state;
  logic [2:0] step;
  logic       accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd           = '0;
    cmd.latch     = accept;
    cmd.spawn     = (state == S_SPAWN);
    cmd.rd_slot   = (state == S_SCAN);
    cmd.mul1      = (state == S_MUL1);
    cmd.vel       = (state == S_VEL);
    cmd.mul2      = (state == S_MUL2);
    cmd.upd       = (state == S_UPD);
    cmd.div_step  = (state == S_DIV);
    cmd.emit_tick = (state == S_EMIT);
    cmd.emit_end  = (state == S_END);
  end

  // Sequencer: spawn in one step, tick walks the slots in ascending order.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= '0;
            state <= (kind == KIND_TICK) ? S_SCAN : S_SPAWN;
          end
        end
        S_SPAWN: state <= S_IDLE;
        S_SCAN: begin
          if (stat.alive_cur) begin
            state <= S_MUL1;
          end else if (idx == LAST_IDX) begin
            state <= S_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MUL1: state <= S_VEL;
        S_VEL:  state <= S_MUL2;
        S_MUL2: state <= S_UPD;
        S_UPD: begin
          step <= '0;
          if (!stat.die) begin
            state <= S_DIV;
          end else if (idx == LAST_IDX) begin
            state <= S_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == 3'd7) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (idx == LAST_IDX) begin
            state <= S_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_END:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/ppu_dp.sv
module ppu_dp #(
  parameter int POOL_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppu_pkg::in_item_t             item,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [23:0]                   cfg_data,
  input  ppu_pkg::ppu_cmd_t             cmd,
  input  logic [$clog2(POOL_SLOTS)-1:0] idx,
  output ppu_pkg::ppu_stat_t            stat,
  output logic                          result_valid,
  output ppu_pkg::res_item_t            result
);
  import ppu_pkg::*;

  localparam int AW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(POOL_SLOTS);

  // Configuration registers.
  logic [15:0]        drag;
  logic signed [23:0] gravity;

  // Particle store, free-slot stack and liveness.
  part_t             part_mem [POOL_SLOTS];
  logic [AW-1:0]     stack_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] stack_wr;
  logic [POOL_SLOTS-1:0] alive;
  logic [CW-1:0]     free_count;

  logic [AW-1:0]     stk_addr;
  logic [AW-1:0]     stk_addr_q;
  logic [AW-1:0]     stk_q;
  logic              stk_wr_q;
  logic [AW-1:0]     spawn_slot;

  in_item_t           inq;
  part_t              rd;
  logic signed [40:0] pvx, pvy, pgd;
  logic signed [40:0] mx, my;
  logic signed [23:0] vx, vy;
  logic               die;
  logic [15:0]        life_new;
  logic signed [23:0] npx, npy;
  logic signed [23:0] npx_q, npy_q;

  logic [23:0] rem;
  logic [23:0] dvs;
  logic [7:0]  quo;

  logic      pend_valid;
  res_item_t pend;
  res_item_t new_res;
  res_item_t none_res;
  res_item_t spawn_res;
  res_item_t end_res;

  logic   mem_we;
  logic [AW-1:0] mem_addr;
  part_t  mem_wdata;

  assign stk_addr   = AW'(free_count - 1'b1);
  assign spawn_slot = stk_wr_q ? stk_q : stk_addr_q;

  assign stat.pool_empty = (free_count == '0);
  assign stat.alive_cur  = alive[idx];
  assign stat.die        = die;

  assign npx = sat24(48'(rd.pos_x) + 48'(mx >>> 8));
  assign npy = sat24(48'(rd.pos_y) + 48'(my >>> 8));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      drag    <= DRAG_RESET;
      gravity <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRAG:    drag    <= cfg_data[15:0];
        CFG_GRAVITY: gravity <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      inq <= item;
    end
  end

  // Particle memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx;
    mem_wdata = rd;
    if (cmd.spawn) begin
      mem_we             = !stat.pool_empty;
      mem_addr           = spawn_slot;
      mem_wdata.pos_x    = inq.pos_x;
      mem_wdata.pos_y    = inq.pos_y;
      mem_wdata.vel_x    = inq.vel_x;
      mem_wdata.vel_y    = inq.vel_y;
      mem_wdata.life     = inq.lifetime;
      mem_wdata.life_max = inq.lifetime;
      mem_wdata.size     = inq.size;
      mem_wdata.color    = inq.color;
    end else if (cmd.upd) begin
      mem_we          = 1'b1;
      mem_wdata.pos_x = npx;
      mem_wdata.pos_y = npy;
      mem_wdata.vel_x = vx;
      mem_wdata.vel_y = vy;
      mem_wdata.life  = life_new;
    end
  end

  // Particle memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      part_mem[mem_addr] <= mem_wdata;
    end
    if (cmd.rd_slot) begin
      rd <= part_mem[idx];
    end
  end

  // Free-slot stack memory: read the top every cycle, push on release.
  always_ff @(posedge clk) begin
    stk_q      <= stack_mem[stk_addr];
    stk_addr_q <= stk_addr;
    if (cmd.upd && die && free_count < FULL_CNT) begin
      stack_mem[AW'(free_count)] <= idx;
    end
  end

  // Stack bookkeeping and liveness.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_wr   <= '0;
      alive      <= '0;
      free_count <= FULL_CNT;
      stk_wr_q   <= 1'b0;
    end else begin
      stk_wr_q <= stack_wr[stk_addr];
      if (cmd.spawn && !stat.pool_empty) begin
        alive[spawn_slot] <= 1'b1;
        free_count        <= free_count - 1'b1;
      end else if (cmd.upd && die) begin
        alive[idx] <= 1'b0;
        if (free_count < FULL_CNT) begin
          stack_wr[AW'(free_count)] <= 1'b1;
          free_count                <= free_count + 1'b1;
        end
      end
    end
  end

  // Motion arithmetic, one registered step per command.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      pvx      <= $signed(rd.vel_x) * $signed({1'b0, drag});
      pvy      <= $signed(rd.vel_y) * $signed({1'b0, drag});
      pgd      <= gravity * $signed({1'b0, inq.dt});
      die      <= (rd.life <= inq.dt);
      life_new <= rd.life - inq.dt;
    end
    if (cmd.vel) begin
      vx <= sat24(48'(pvx >>> 16));
      vy <= sat24(48'(pvy >>> 16) + 48'(pgd >>> 8));
    end
    if (cmd.mul2) begin
      mx <= vx * $signed({1'b0, inq.dt});
      my <= vy * $signed({1'b0, inq.dt});
    end
    if (cmd.upd) begin
      npx_q <= npx;
      npy_q <= npy;
    end
  end

  // Opacity divider: 255 * life / life_max, one quotient bit per step.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rem <= {life_new, 8'd0} - {8'd0, life_new};
      dvs <= {1'b0, rd.life_max, 7'd0};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[6:0], 1'b1};
      end else begin
        quo <= {quo[6:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

  // Result records.
  always_comb begin
    none_res      = '0;
    none_res.last = 1'b1;

    new_res            = '0;
    new_res.slot       = 6'(idx);
    new_res.present    = 1'b1;
    new_res.draw_x     = npx_q;
    new_res.draw_y     = npy_q;
    new_res.draw_size  = rd.size;
    new_res.draw_color = rd.color;
    new_res.alpha      = (rd.life_max == '0) ? 8'd0 : quo;

    spawn_res            = '0;
    spawn_res.slot       = 6'(spawn_slot);
    spawn_res.present    = 1'b1;
    spawn_res.draw_x     = inq.pos_x;
    spawn_res.draw_y     = inq.pos_y;
    spawn_res.draw_size  = inq.size;
    spawn_res.draw_color = inq.color;
    spawn_res.alpha      = (inq.lifetime == '0) ? 8'd0 : 8'd255;
    spawn_res.last       = 1'b1;

    end_res      = pend;
    end_res.last = 1'b1;
  end

  // Output register; one survivor is held back until the next is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.spawn) begin
        result_valid <= 1'b1;
        result       <= stat.pool_empty ? none_res : spawn_res;
      end else if (cmd.emit_tick) begin
        if (pend_valid) begin
          result_valid <= 1'b1;
          result       <= pend;
        end
        pend       <= new_res;
        pend_valid <= 1'b1;
      end else if (cmd.emit_end) begin
        result_valid <= 1'b1;
        result       <= pend_valid ? end_res : none_res;
        pend_valid   <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/ppu_checker.sv
`include "particle_pool_update_engine_core_macros.svh"

module ppu_sva (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_valid,
  input ppu_pkg::res_item_t result
);
  import ppu_pkg::*;

  // An empty result always closes its item.
  `PPU_ASSERT_NOW(a_empty_last, result_valid && !result.present, result.last, "empty result not last")

  // An empty result carries no slot and no opacity.
  `PPU_ASSERT_NOW(a_empty_zero, result_valid && !result.present, result.slot == 6'd0 && result.alpha == 8'd0, "empty result not cleared")

  // An accepted item makes the engine busy.
  `PPU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // After the final result of an item no result follows at once.
  `PPU_ASSERT_NEXT(a_last_gap, result_valid && result.last, !result_valid, "result right after last")

endmodule

bind particle_pool_update_engine_core ppu_sva u_ppu_sva (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);
